>>> rtl/core/ssdr_pkg.sv
// ----------------------------------------------------------------------------
// ssdr_pkg: shared types and constants of the seven-segment digit reader
// Segment bit positions, digit codes, register indexes and the flag decoder.
// ----------------------------------------------------------------------------
package ssdr_pkg;

  localparam int MaxSideDefault = 255;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 16;
  localparam int SideW     = 8;
  localparam int AreaW     = 16;
  localparam int PixelW    = 8;
  localparam int CodeW     = 4;
  localparam int SegW      = 7;

  localparam logic [PixelW-1:0] PIXEL_LIT = 8'd255;

  localparam logic [SideW-1:0]    WIDTH_RESET = 8'd1;
  localparam logic [SideW-1:0]    HEIGHT_RESET = 8'd1;
  localparam logic [AreaW-1:0]    AREA_LIMIT_RESET = 16'd190;

  typedef enum logic [CfgIndexW-1:0] {
    REG_REGION_WIDTH  = 2'd0,
    REG_REGION_HEIGHT = 2'd1,
    REG_NARROW_LIMIT  = 2'd2,
    REG_UNUSED        = 2'd3
  } cfg_reg_e;

  localparam logic [SegW-1:0] SEG_A = 7'h01;
  localparam logic [SegW-1:0] SEG_B = 7'h02;
  localparam logic [SegW-1:0] SEG_C = 7'h04;
  localparam logic [SegW-1:0] SEG_D = 7'h08;
  localparam logic [SegW-1:0] SEG_E = 7'h10;
  localparam logic [SegW-1:0] SEG_F = 7'h20;
  localparam logic [SegW-1:0] SEG_G = 7'h40;
  localparam logic [SegW-1:0] SEG_ALL = 7'h7F;

  localparam logic [CodeW-1:0] DIGIT_ONE   = 4'd1;
  localparam logic [CodeW-1:0] DIGIT_TWO   = 4'd2;
  localparam logic [CodeW-1:0] DIGIT_THREE = 4'd3;
  localparam logic [CodeW-1:0] DIGIT_FOUR  = 4'd4;
  localparam logic [CodeW-1:0] DIGIT_FIVE  = 4'd5;
  localparam logic [CodeW-1:0] DIGIT_SIX   = 4'd6;
  localparam logic [CodeW-1:0] DIGIT_SEVEN = 4'd7;
  localparam logic [CodeW-1:0] DIGIT_EIGHT = 4'd8;
  localparam logic [CodeW-1:0] DIGIT_NINE  = 4'd9;
  localparam logic [CodeW-1:0] DIGIT_ERROR = 4'd10;

  function automatic logic [CodeW-1:0] decode_flags(input logic [SegW-1:0] s);
    logic [CodeW-1:0] code;
    case (s)
      SEG_A | SEG_B | SEG_D | SEG_E | SEG_G:         code = DIGIT_TWO;
      SEG_A | SEG_B | SEG_C | SEG_D | SEG_G:         code = DIGIT_THREE;
      SEG_B | SEG_C | SEG_F | SEG_G:                 code = DIGIT_FOUR;
      SEG_A | SEG_C | SEG_D | SEG_F | SEG_G:         code = DIGIT_FIVE;
      SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G: code = DIGIT_SIX;
      SEG_A | SEG_B | SEG_C | SEG_D:                 code = DIGIT_SEVEN;
      SEG_A | SEG_B | SEG_C:                         code = DIGIT_SEVEN;
      SEG_ALL:                                       code = DIGIT_EIGHT;
      SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G: code = DIGIT_NINE;
      default:                                       code = DIGIT_ERROR;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/core/seven_segment_digit_reader_top.sv
// ----------------------------------------------------------------------------
// seven_segment_digit_reader_top: crossing-line seven-segment digit reader
// Scans a binarized digit region in raster order and emits one digit word
// per region, at the word marked last.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata (low bit up)                    | tlast
//  ----------+-----+---------------------------------------+------------
//  s_axis    | in  | [7:0] pixel_value                     | region_end
//  m_axis    | out | [3:0] digit_code, [10:4] segment_flags| -
//  cfg       | in  | we / 2-bit index / 16-bit data        | -
//
//  One pixel word per cycle, sustained but for the stall below. The digit
//  word is valid in the cycle after the edge that moves the last pixel word
//  from the input register through scan/decode into the output register.
//  Input stalls only while a region's last word sits in the input register
//  and the previous result is still unread in the output register.
//  Reset: width 1, height 1, narrow limit 190, derived lines zero, counters
//  and flags clear. No clearing pass.
// ----------------------------------------------------------------------------
module seven_segment_digit_reader_top #(
  parameter int MAX_SIDE = ssdr_pkg::MaxSideDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // cfg write port
  input  logic                           cfg_we_i,
  input  logic [ssdr_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [ssdr_pkg::CfgDataW-1:0]  cfg_data_i,
  // pixel stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,  // [7:0] pixel_value
  input  logic                           s_axis_tlast_i,  // region_end
  // digit stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [15:0]                    m_axis_tdata_o   // [3:0] digit_code,
                                                          // [10:4] segment_flags
);

  localparam int RowW = $clog2(MAX_SIDE + 1);
  localparam int CmpW = (RowW > ssdr_pkg::SideW) ? RowW : ssdr_pkg::SideW;
  localparam int SW   = ssdr_pkg::SideW;
  localparam int SegW = ssdr_pkg::SegW;

  // configuration and derived lines
  logic [SW-1:0]                  width_q, height_q;
  logic [ssdr_pkg::AreaW-1:0]     limit_q;
  logic [SW-1:0]                  half_q, upper_q, lower_q;
  logic [16:0]                    upper_prod;
  logic [16:0]                    lower_prod;
  ssdr_pkg::cfg_reg_e             cfg_sel;

  // x / 3 == (x * 171) >> 9 holds exactly for x < 512
  assign upper_prod = 17'(cfg_data_i[SW-1:0]) * 17'd171;
  assign lower_prod = 17'({cfg_data_i[SW-1:0], 1'b0}) * 17'd171;
  assign cfg_sel    = ssdr_pkg::cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ssdr_pkg::WIDTH_RESET;
      height_q <= ssdr_pkg::HEIGHT_RESET;
      limit_q  <= ssdr_pkg::AREA_LIMIT_RESET;
      half_q   <= '0;
      upper_q  <= '0;
      lower_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_sel)
        ssdr_pkg::REG_REGION_WIDTH: begin
          width_q <= cfg_data_i[SW-1:0];
          half_q  <= {1'b0, cfg_data_i[SW-1:1]};
        end
        ssdr_pkg::REG_REGION_HEIGHT: begin
          height_q <= cfg_data_i[SW-1:0];
          upper_q  <= upper_prod[9 +: SW];
          lower_q  <= lower_prod[9 +: SW];
        end
        ssdr_pkg::REG_NARROW_LIMIT: begin
          limit_q <= cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  // input register
  logic in_valid_q, lit_q, last_q;
  logic advance;
  logic out_valid_q;

  assign advance         = in_valid_q && (!last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      lit_q  <= s_axis_tdata_i == ssdr_pkg::PIXEL_LIT;
      last_q <= s_axis_tlast_i;
    end
  end

  // scan position and segment flags
  logic [RowW-1:0] row_q, row_d;
  logic [SW-1:0]   col_q, col_d;
  logic [SegW-1:0] flags_q, flags_d, hit, flags_new;
  logic [CmpW-1:0] r_ext;
  logic            on_half, left;

  assign r_ext   = CmpW'(row_q);
  assign on_half = col_q == half_q;
  assign left    = col_q < half_q;

  always_comb begin
    hit = '0;
    if (lit_q && r_ext < CmpW'(height_q)) begin
      if (on_half) begin
        if (r_ext < CmpW'(upper_q)) begin
          hit = hit | ssdr_pkg::SEG_A;
        end else if (r_ext > CmpW'(upper_q) && r_ext < CmpW'(lower_q)) begin
          hit = hit | ssdr_pkg::SEG_G;
        end else begin
          hit = hit | ssdr_pkg::SEG_D;
        end
      end
      if (r_ext == CmpW'(upper_q)) begin
        hit = hit | (left ? ssdr_pkg::SEG_F : ssdr_pkg::SEG_B);
      end
      if (r_ext == CmpW'(lower_q)) begin
        hit = hit | (left ? ssdr_pkg::SEG_E : ssdr_pkg::SEG_C);
      end
    end
  end

  assign flags_new = flags_q | hit;

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    flags_d = flags_q;
    if (advance) begin
      if ({1'b0, col_q} + 9'd1 >= {1'b0, width_q}) begin
        col_d = '0;
        if (row_q < RowW'(MAX_SIDE)) begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        col_d = col_q + SW'(1);
      end
      flags_d = flags_new;
      if (last_q) begin
        row_d   = '0;
        col_d   = '0;
        flags_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      flags_q <= '0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      flags_q <= flags_d;
    end
  end

  // decode and output register
  logic [ssdr_pkg::CodeW-1:0] code;
  logic [ssdr_pkg::CodeW-1:0] out_code_q;
  logic [SegW-1:0]            out_flags_q;

  ssdr_decoder u_decoder (
    .region_width_i      (width_q),
    .region_height_i     (height_q),
    .narrow_area_limit_i (limit_q),
    .segment_flags_i     (flags_new),
    .digit_code_o        (code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      out_code_q  <= code;
      out_flags_q <= flags_new;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_flags_q, out_code_q};

endmodule

>>> rtl/core/ssdr_decoder.sv
// ----------------------------------------------------------------------------
// ssdr_decoder: digit decision for one finished region
// Narrow regions read as one; otherwise the lit flags go through the table.
// ----------------------------------------------------------------------------
module ssdr_decoder (
  input  logic [ssdr_pkg::SideW-1:0] region_width_i,
  input  logic [ssdr_pkg::SideW-1:0] region_height_i,
  input  logic [ssdr_pkg::AreaW-1:0] narrow_area_limit_i,
  input  logic [ssdr_pkg::SegW-1:0]  segment_flags_i,
  output logic [ssdr_pkg::CodeW-1:0] digit_code_o
);

  logic [ssdr_pkg::AreaW-1:0] area;
  logic                       narrow;

  assign area   = ssdr_pkg::AreaW'(region_width_i) * ssdr_pkg::AreaW'(region_height_i);
  assign narrow = area < narrow_area_limit_i;

  always_comb begin
    if (narrow) begin
      digit_code_o = ssdr_pkg::DIGIT_ONE;
    end else begin
      digit_code_o = ssdr_pkg::decode_flags(segment_flags_i);
    end
  end

endmodule

>>> rtl/core/ssdr_checker.sv
// ----------------------------------------------------------------------------
// ssdr_checker: port-level checks for the seven-segment digit reader
// Watches the result stream; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ssdr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // no result while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result word changed");

  // digit code between one and the error code, padding zero
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[3:0] != 4'd0
                        && m_axis_tdata_o[3:0] <= ssdr_pkg::DIGIT_ERROR
                        && m_axis_tdata_o[15:11] == 5'd0)
    else $error("digit code out of range");

  // an eight needs every segment lit
  a_eight_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[3:0] == ssdr_pkg::DIGIT_EIGHT
      |-> m_axis_tdata_o[10:4] == ssdr_pkg::SEG_ALL)
    else $error("eight without all segments");

endmodule

bind seven_segment_digit_reader_top ssdr_checker u_ssdr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
